// ----- rtl/ppt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants for the palindromic prime tester.
// ----------------------------------------------------------------------------
package ppt_pkg;

  // decimal radix used by the digit reversal
  localparam int unsigned DEC_BASE = 10;

  // first trial divisor
  localparam int unsigned FIRST_DIVISOR = 2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REV_GO,
    ST_REV_WAIT,
    ST_TRIAL_GO,
    ST_TRIAL_WAIT,
    ST_REPORT
  } ppt_state_e;

endpackage

// ----- rtl/ppt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_div
// Shared restoring divider: one quotient bit per cycle,
// done pulses for one cycle when quotient and remainder are valid.
// ----------------------------------------------------------------------------
module ppt_div #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o,
  output logic [W-1:0] remainder_o
);

  localparam int unsigned CW = $clog2(W);

  logic         run_q;
  logic         done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0] quo_q;
  logic [W-1:0] rem_q;
  logic [W-1:0] den_q;

  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic         fits;

  // one restoring step: shift in next dividend bit, try to subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[W-1]};
    diff   = rem_sh - {1'b0, den_q};
    fits   = !diff[W];
  end

  // control: run flag, step counter, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient shifts in from the dividend, remainder builds up
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[W-2:0], fits};
      rem_q <= fits ? diff[W-1:0] : rem_sh[W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- rtl/palindromic_prime_test_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindromic_prime_test_top
// Tests one number per word for primality and decimal palindrome.
// ----------------------------------------------------------------------------
// Usage:
//   - a word is taken when start is high and busy is low; candidate_i is
//     masked to the low min(NUM_BITS,16) bits
//   - one result word per input word: done_o is high for exactly one cycle
//     with is_prime_o, is_palindrome_o and is_palindromic_prime_o valid
//   - busy stays high from the accepting edge until the cycle after done_o
//   - all divisions run on one shared divider of width V = min(NUM_BITS,16)
//   - digit reversal divides by ten once per decimal digit, then trial
//     division tries each divisor from 2 up to the first divisor that
//     leaves no remainder, or up to n-1 for a prime
//   - one word in flight at a time
//   - reset returns the sequencer to idle; no state is kept between words
//   - the receiver cannot stall, results are shown once and dropped
// ----------------------------------------------------------------------------
module palindromic_prime_test_top
  import ppt_pkg::*;
#(
  parameter int unsigned NUM_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] candidate_i,
  output logic        done_o,
  output logic        is_prime_o,
  output logic        is_palindrome_o,
  output logic        is_palindromic_prime_o
);

  localparam int unsigned VW = (NUM_BITS < 16) ? NUM_BITS : 16;
  localparam int unsigned RW = VW + 4;

  ppt_state_e state_q, state_d;

  logic [VW-1:0] n_q, n_d;
  logic [VW-1:0] work_q, work_d;
  logic [RW-1:0] rev_q, rev_d;
  logic [VW-1:0] div_q, div_d;
  logic          prime_q, prime_d;
  logic          pal_q, pal_d;

  logic          accept;
  logic          dv_start;
  logic [VW-1:0] dv_dividend;
  logic [VW-1:0] dv_divisor;
  logic          dv_done;
  logic [VW-1:0] dv_quo;
  logic [VW-1:0] dv_rem;

  assign accept = start && (state_q == ST_IDLE);

  // shared divider
  ppt_div #(
    .W(VW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dv_start),
    .dividend_i  (dv_dividend),
    .divisor_i   (dv_divisor),
    .done_o      (dv_done),
    .quotient_o  (dv_quo),
    .remainder_o (dv_rem)
  );

  // divider operand select
  always_comb begin
    if (state_q == ST_REV_GO) begin
      dv_dividend = work_q;
      dv_divisor  = VW'(DEC_BASE);
    end else begin
      dv_dividend = n_q;
      dv_divisor  = div_q;
    end
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    work_d   = work_q;
    rev_d    = rev_q;
    div_d    = div_q;
    prime_d  = prime_q;
    pal_d    = pal_q;
    dv_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          n_d     = candidate_i[VW-1:0];
          work_d  = candidate_i[VW-1:0];
          rev_d   = '0;
          state_d = ST_REV_GO;
        end
      end
      ST_REV_GO: begin
        if (work_q == '0) begin
          // all digits consumed
          pal_d = (rev_q == RW'(n_q));
          if (n_q < VW'(FIRST_DIVISOR)) begin
            prime_d = 1'b0;
            state_d = ST_REPORT;
          end else begin
            div_d   = VW'(FIRST_DIVISOR);
            state_d = ST_TRIAL_GO;
          end
        end else begin
          dv_start = 1'b1;
          state_d  = ST_REV_WAIT;
        end
      end
      ST_REV_WAIT: begin
        if (dv_done) begin
          // rev = rev * 10 + digit
          rev_d   = RW'({rev_q, 3'b000}) + RW'({rev_q, 1'b0}) + RW'(dv_rem);
          work_d  = dv_quo;
          state_d = ST_REV_GO;
        end
      end
      ST_TRIAL_GO: begin
        if (div_q == n_q) begin
          prime_d = 1'b1;
          state_d = ST_REPORT;
        end else begin
          dv_start = 1'b1;
          state_d  = ST_TRIAL_WAIT;
        end
      end
      ST_TRIAL_WAIT: begin
        if (dv_done) begin
          if (dv_rem == '0) begin
            prime_d = 1'b0;
            state_d = ST_REPORT;
          end else begin
            div_d   = div_q + 1'b1;
            state_d = ST_TRIAL_GO;
          end
        end
      end
      ST_REPORT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    work_q  <= work_d;
    rev_q   <= rev_d;
    div_q   <= div_d;
    prime_q <= prime_d;
    pal_q   <= pal_d;
  end

  // result word
  assign busy                   = (state_q != ST_IDLE);
  assign done_o                 = (state_q == ST_REPORT);
  assign is_prime_o             = prime_q;
  assign is_palindrome_o        = pal_q;
  assign is_palindromic_prime_o = prime_q && pal_q;

  // a result strobe never repeats on the next cycle
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // an accepted word makes the block busy
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // divider completes only while the sequencer waits for it
  a_div_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_done |-> (state_q == ST_REV_WAIT || state_q == ST_TRIAL_WAIT))
    else $error("divider finished with no waiting step");

  // a prime report is never given for zero or one
  a_prime_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_prime_o) |-> (n_q >= VW'(FIRST_DIVISOR)))
    else $error("prime reported below two");

  // divider is never started back to back
  a_div_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |=> !dv_start)
    else $error("divider restarted back to back");

endmodule

// ----- dv/palindromic_prime_test_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindromic_prime_test_top_test
// Feeds numbers to the palindromic prime tester and checks every verdict
// word against a local trial-division and digit-reversal predictor; directed
// corner values first, then a random mix kept mostly to cheap candidates.
// ----------------------------------------------------------------------------
module palindromic_prime_test_top_test;

  localparam int unsigned WORD_BITS = 16;
  localparam int unsigned NUM_RANDOM = 76;

  // one expected verdict per accepted word
  typedef struct packed {
    logic [15:0] candidate;
    logic        is_prime;
    logic        is_palindrome;
    logic        is_palindromic_prime;
  } verdict_t;

  // keeps pending verdicts and compares them with what comes out
  class prime_verdict_board;
    verdict_t    pending_verdicts[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // trial division and decimal reversal on the masked number
    function verdict_t classify_number(logic [15:0] value);
      verdict_t    v;
      int unsigned n;
      int unsigned d;
      int unsigned rest;
      int unsigned reversed;
      logic [15:0] mask;
      mask = (WORD_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << WORD_BITS) - 1);
      n = int'(value & mask);
      v.candidate = value;
      v.is_prime = (n >= ppt_pkg::FIRST_DIVISOR);
      for (d = ppt_pkg::FIRST_DIVISOR; d < n && v.is_prime; d++) begin
        if (n % d == 0) v.is_prime = 1'b0;
      end
      reversed = 0;
      rest = n;
      while (rest != 0) begin
        reversed = reversed * ppt_pkg::DEC_BASE + rest % ppt_pkg::DEC_BASE;
        rest = rest / ppt_pkg::DEC_BASE;
      end
      v.is_palindrome = (reversed == n);
      v.is_palindromic_prime = v.is_prime && v.is_palindrome;
      return v;
    endfunction

    function void note_candidate(logic [15:0] value);
      pending_verdicts.push_back(classify_number(value));
    endfunction

    function void compare_flag(string name, logic [15:0] cand, logic exp_bit,
                               logic act_bit);
      if (exp_bit !== act_bit) begin
        $display("%0t: %s mismatch for candidate %0d: expected %0b actual %0b",
                 $time, name, cand, exp_bit, act_bit);
        errors++;
      end
    endfunction

    function void check_verdict(logic prime, logic pal, logic pal_prime);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result word: expected none actual %0b%0b%0b",
                 $time, prime, pal, pal_prime);
        errors++;
        return;
      end
      v = pending_verdicts.pop_front();
      compare_flag("is_prime", v.candidate, v.is_prime, prime);
      compare_flag("is_palindrome", v.candidate, v.is_palindrome, pal);
      compare_flag("is_palindromic_prime", v.candidate, v.is_palindromic_prime,
                   pal_prime);
    endfunction

    function int unsigned pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [15:0] candidate_i;
  logic        done_o;
  logic        is_prime_o;
  logic        is_palindrome_o;
  logic        is_palindromic_prime_o;

  prime_verdict_board board;

  palindromic_prime_test_top #(
    .NUM_BITS(WORD_BITS)
  ) DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start                 (start),
    .busy                  (busy),
    .candidate_i           (candidate_i),
    .done_o                (done_o),
    .is_prime_o            (is_prime_o),
    .is_palindrome_o       (is_palindrome_o),
    .is_palindromic_prime_o(is_palindromic_prime_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result monitor, samples the values present during the cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_verdict(is_prime_o, is_palindrome_o, is_palindromic_prime_o);
    end
  end

  // offer one word, optionally after a random gap, until it is taken
  task automatic send_word(input logic [15:0] value, input bit may_idle);
    if (may_idle && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    candidate_i <= value;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_candidate(value);
  endtask

  // random decimal palindrome of 1 to 5 digits, always below 2^16
  function automatic logic [15:0] make_palindrome();
    int unsigned a;
    int unsigned b;
    int unsigned c;
    a = $urandom_range(1, 9);
    b = $urandom_range(0, 9);
    c = $urandom_range(0, 9);
    case ($urandom_range(0, 4))
      0: return 16'(a);
      1: return 16'(a * 11);
      2: return 16'(a * 101 + b * 10);
      3: return 16'(a * 1001 + b * 110);
      default: return 16'(($urandom_range(1, 5)) * 10001 + b * 1010 + c * 100);
    endcase
  endfunction

  // random candidate; large primes are stepped down to keep the run short
  function automatic logic [15:0] pick_candidate();
    logic [15:0] value;
    int unsigned pick;
    verdict_t    probe;
    pick = $urandom_range(99);
    if (pick < 40) value = 16'($urandom_range(0, 999));
    else if (pick < 55) value = make_palindrome();
    else if (pick < 80) value = 16'($urandom_range(0, 65535));
    else if (pick < 90) value = 16'(65535 - $urandom_range(0, 31));
    else value = 16'(1) << $urandom_range(0, 15);
    probe = board.classify_number(value);
    if (value > 4000 && probe.is_prime) value = value - 16'd1;
    return value;
  endfunction

  // corner values: zero, one, single digits, palindromes prime and not
  logic [15:0] corner_words[] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd7, 16'd9, 16'd10, 16'd11, 16'd12,
    16'd22, 16'd101, 16'd121, 16'd131, 16'd919, 16'd929, 16'd997, 16'd1000,
    16'd1001, 16'd12321, 16'd10301, 16'd32768, 16'd65534, 16'd65535
  };

  // stimulus
  initial begin
    board = new();
    rst_ni <= 1'b0;
    start <= 1'b0;
    candidate_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_words[i]) send_word(corner_words[i], 1'b1);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // hold off until the block has drained
      if (i == NUM_RANDOM / 2) begin
        start <= 1'b0;
        do @(posedge clk_i); while (board.pending() != 0);
      end
      // a stretch with back-to-back words
      send_word(pick_candidate(), !(i >= 20 && i < 45));
    end
    start <= 1'b0;

    do @(posedge clk_i); while (board.pending() != 0);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit, several times the slowest expected run
  initial begin
    #200_000_000;
    $display("%0t: timeout with %0d verdicts outstanding", $time, board.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule
